// ===== hdl/hdc_pkg.sv =====
// Shared constants, types and codes for the half-wave DC removal and qualifier.
`timescale 1ns / 1ps
`default_nettype none
package hdc_pkg;

  localparam int WindowDepth  = 256;
  localparam int SampleBits   = 12;
  localparam int SlotBits     = $clog2(WindowDepth);
  localparam int FillBits     = $clog2(WindowDepth + 1);
  localparam int SumBits      = SampleBits + SlotBits;
  localparam int DividendBits = SumBits + 4;
  localparam int DivCntBits   = $clog2(DividendBits);
  localparam int MeanBits     = SampleBits + 4;
  localparam int DiffBits     = MeanBits + 2;
  localparam int GainBits     = 16;
  localparam int ProdBits     = DiffBits + GainBits + 1;
  localparam int GainShift    = 15;
  localparam int CenterBits   = 16;
  localparam int LossBits     = 16;
  localparam int ClipBits     = 8;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PRESENT_LEVEL = 3'd0,
    CFG_LOSS_LIMIT    = 3'd1,
    CFG_CLIP_LEVEL    = 3'd2,
    CFG_CLIP_CONFIRM  = 3'd3,
    CFG_PU_GAIN       = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [SampleBits-1:0] present_level;
    logic [LossBits-1:0]   loss_limit;
    logic [SampleBits-1:0] clip_level;
    logic [ClipBits-1:0]   clip_confirm;
    logic [GainBits-1:0]   pu_gain;
  } cfg_t;

  // Window control from the sequencer
  typedef struct packed {
    logic take;
    logic update;
  } win_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic lost;
    logic clipped;
  } qual_t;

endpackage
`default_nettype wire

// ===== hdl/hdc_if.sv =====
// Handshake channel interfaces: sample input, result output and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface hdc_in_if;
  import hdc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] grid_sample;
  modport source (output valid, output grid_sample, input ready);
  modport sink (input valid, input grid_sample, output ready);
endinterface

interface hdc_out_if;
  import hdc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [MeanBits-1:0]          mean_q4;
  logic signed [CenterBits-1:0] ac_scaled;
  logic                         signal_valid;
  logic                         clipped;
  modport source (output valid, output mean_q4, output ac_scaled,
                  output signal_valid, output clipped, input ready);
  modport sink (input valid, input mean_q4, input ac_scaled,
                input signal_valid, input clipped, output ready);
endinterface

interface hdc_cfg_if;
  import hdc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/halfwave_dc_removal_and_qualifier.sv =====
// An accepted sample goes through the load, start, divide, multiply and done states
// in turn; the 24-step serial divide of the Q4 sum by the fill count is the longest
// step. Input is not ready while a sample is in work.
// The result register lets the next sample enter while a result waits to be taken.
// Reset: asynchronous, active low; empty window, zero sum, signal counted as lost,
// registers at their defaults. Window contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module halfwave_dc_removal_and_qualifier (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hdc_in_if.sink     in_i,
  hdc_out_if.source  out_o,
  hdc_cfg_if.sink    cfg_i
);
  import hdc_pkg::*;

  state_e state_q, state_d;
  cfg_t   cfg_q;

  logic [SampleBits-1:0]       sample_q;
  logic [MeanBits-1:0]         mean_q;
  logic signed [ProdBits-1:0]  prod_q;
  logic                        out_valid_q;
  logic [MeanBits-1:0]         out_mean_q;
  logic [CenterBits-1:0]       out_center_q;
  logic                        out_sig_q, out_clip_q;

  win_ctrl_t           win_ctrl;
  logic [SumBits-1:0]  win_sum;
  logic [FillBits-1:0] win_fill;
  logic                win_full;
  div_stat_t           div_stat;
  logic [MeanBits-1:0] div_quot;
  logic                div_start;
  qual_t               qual;

  logic in_ready, in_take, mean_load, prod_load, out_load;
  logic signed [DiffBits-1:0]              diff;
  logic signed [GainBits:0]                gain_s;
  logic signed [ProdBits-1:0]              prod_d;
  logic signed [ProdBits-GainShift-1:0]    shifted;
  logic [CenterBits-1:0]                   center_sat;

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.present_level <= SampleBits'(200);
      cfg_q.loss_limit    <= LossBits'(1000);
      cfg_q.clip_level    <= SampleBits'(4000);
      cfg_q.clip_confirm  <= ClipBits'(3);
      cfg_q.pu_gain       <= GainBits'(8192);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PRESENT_LEVEL: cfg_q.present_level <= cfg_i.data[SampleBits-1:0];
        CFG_LOSS_LIMIT:    cfg_q.loss_limit    <= cfg_i.data[LossBits-1:0];
        CFG_CLIP_LEVEL:    cfg_q.clip_level    <= cfg_i.data[SampleBits-1:0];
        CFG_CLIP_CONFIRM:  cfg_q.clip_confirm  <= cfg_i.data[ClipBits-1:0];
        CFG_PU_GAIN:       cfg_q.pu_gain       <= cfg_i.data[GainBits-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_stat.done) state_d = ST_MUL;
      ST_MUL:   state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready        = 1'b0;
    win_ctrl.take   = 1'b0;
    win_ctrl.update = 1'b0;
    div_start       = 1'b0;
    mean_load       = 1'b0;
    prod_load       = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready      = 1'b1;
        win_ctrl.take = in_i.valid;
      end
      ST_LOAD:  win_ctrl.update = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DIV:   mean_load = div_stat.done;
      ST_MUL:   prod_load = 1'b1;
      ST_DONE:  out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;
  assign in_take    = in_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  hdc_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .sample_i (sample_q),
    .sum_o    (win_sum),
    .fill_o   (win_fill),
    .full_o   (win_full)
  );

  hdc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({win_sum, 4'b0000}),
    .divisor_i  (win_fill),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  hdc_qualifier u_qualifier (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (win_ctrl.update),
    .sample_i (sample_q),
    .cfg_i    (cfg_q),
    .qual_o   (qual)
  );

  // Centre and scale: (sample*16 - mean) * gain, floored by the arithmetic shift and saturated to 16 bits
  assign diff    = $signed({2'b00, sample_q, 4'b0000}) - $signed({2'b00, mean_q});
  assign gain_s  = $signed({1'b0, cfg_q.pu_gain});
  assign prod_d  = diff * gain_s;
  assign shifted = prod_q[ProdBits-1:GainShift];

  always_comb begin
    if ((&shifted[ProdBits-GainShift-1:CenterBits-1]) ||
        !(|shifted[ProdBits-GainShift-1:CenterBits-1])) begin
      center_sat = shifted[CenterBits-1:0];
    end else if (shifted[ProdBits-GainShift-1]) begin
      center_sat = {1'b1, {(CenterBits-1){1'b0}}};
    end else begin
      center_sat = {1'b0, {(CenterBits-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= in_i.grid_sample;
    end
    if (mean_load) begin
      mean_q <= div_quot;
    end
    if (prod_load) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      out_mean_q   <= mean_q;
      out_center_q <= center_sat;
      out_sig_q    <= win_full && !qual.lost && !qual.clipped;
      out_clip_q   <= qual.clipped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mean_q4      = out_mean_q;
  assign out_o.ac_scaled    = $signed(out_center_q);
  assign out_o.signal_valid = out_sig_q;
  assign out_o.clipped      = out_clip_q;

endmodule
`default_nettype wire

// ===== hdl/hdc_window.sv =====
// Sliding sample window with running sum, write slot and fill count.
`timescale 1ns / 1ps
`default_nettype none
module hdc_window (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hdc_pkg::win_ctrl_t             ctrl_i,
  input  wire logic [hdc_pkg::SampleBits-1:0] sample_i,
  output logic [hdc_pkg::SumBits-1:0]         sum_o,
  output logic [hdc_pkg::FillBits-1:0]        fill_o,
  output logic                                full_o
);
  import hdc_pkg::*;

  logic [SampleBits-1:0] mem [WindowDepth];
  logic [SampleBits-1:0] old_q;
  logic [SlotBits-1:0]   slot_q, slot_d;
  logic [FillBits-1:0]   fill_q, fill_d;
  logic [SumBits-1:0]    sum_q, sum_d;
  logic                  full;

  assign full = (fill_q >= FillBits'(WindowDepth));

  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (ctrl_i.update) begin
      slot_d = (slot_q == SlotBits'(WindowDepth - 1)) ? '0 : slot_q + 1'b1;
      if (!full) begin
        fill_d = fill_q + 1'b1;
        sum_d  = sum_q + SumBits'(sample_i);
      end else begin
        // drop the oldest sample as the new one takes its slot
        sum_d = sum_q - SumBits'(old_q) + SumBits'(sample_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      slot_q <= slot_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      old_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      mem[slot_q] <= sample_i;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;
  assign full_o = full;

endmodule
`default_nettype wire

// ===== hdl/hdc_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the window mean.
`timescale 1ns / 1ps
`default_nettype none
module hdc_divider (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [hdc_pkg::DividendBits-1:0] dividend_i,
  input  wire logic [hdc_pkg::FillBits-1:0]     divisor_i,
  output hdc_pkg::div_stat_t                    stat_o,
  output logic [hdc_pkg::MeanBits-1:0]          quot_o
);
  import hdc_pkg::*;

  logic                    busy_q, done_q;
  logic [DivCntBits-1:0]   cnt_q;
  logic [DividendBits-1:0] dvd_q, quo_q;
  logic [FillBits-1:0]     rem_q, dvs_q;
  logic [FillBits:0]       trial, trial_sub;
  logic                    ge;
  logic [FillBits-1:0]     rem_d;

  assign trial     = {rem_q, dvd_q[DividendBits-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign ge        = (trial >= {1'b0, dvs_q});
  assign rem_d     = ge ? trial_sub[FillBits-1:0] : trial[FillBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntBits'(DividendBits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DividendBits-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[DividendBits-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  // the quotient never exceeds the largest sample in Q4
  assign quot_o      = quo_q[MeanBits-1:0];

endmodule
`default_nettype wire

// ===== hdl/hdc_qualifier.sv =====
// Loss and clip run counters that qualify the input signal.
`timescale 1ns / 1ps
`default_nettype none
module hdc_qualifier (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           update_i,
  input  wire logic [hdc_pkg::SampleBits-1:0] sample_i,
  input  wire hdc_pkg::cfg_t                  cfg_i,
  output hdc_pkg::qual_t                      qual_o
);
  import hdc_pkg::*;

  logic [LossBits-1:0] since_q, since_d;
  logic [ClipBits-1:0] clip_q, clip_d;

  always_comb begin
    since_d = since_q;
    clip_d  = clip_q;
    if (update_i) begin
      if (sample_i >= cfg_i.present_level) begin
        since_d = '0;
      end else if (since_q < cfg_i.loss_limit) begin
        since_d = since_q + 1'b1;
      end
      if (sample_i >= cfg_i.clip_level) begin
        if (clip_q < cfg_i.clip_confirm) begin
          clip_d = clip_q + 1'b1;
        end
      end else begin
        clip_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q <= '1;
      clip_q  <= '0;
    end else begin
      since_q <= since_d;
      clip_q  <= clip_d;
    end
  end

  assign qual_o.lost    = (since_q >= cfg_i.loss_limit);
  assign qual_o.clipped = (clip_q >= cfg_i.clip_confirm);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the half-wave DC removal and signal qualifier.
`timescale 1ns / 1ps
module testbench;
  import hdc_pkg::*;

  localparam int SampleMax   = (1 << SampleBits) - 1;
  localparam int CycleLimit  = 1000000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 64;
  localparam int PrintLimit  = 40;

  typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_e;

  typedef struct packed {
    logic [MeanBits-1:0]          mean_q4;
    logic signed [CenterBits-1:0] ac_scaled;
    logic                         signal_valid;
    logic                         clipped;
  } grid_result_t;

  typedef struct {
    logic [SampleBits-1:0] sample;
    bit                    typed;
    grid_result_t          want;
  } probe_row_t;

  typedef struct {
    logic [CfgDataBits-1:0] present;
    logic [CfgDataBits-1:0] loss;
    logic [CfgDataBits-1:0] clip;
    logic [CfgDataBits-1:0] confirm;
    logic [CfgDataBits-1:0] gain;
    pace_e                  pace;
    int                     items;
  } reg_phase_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hdc_in_if  in_if ();
  hdc_out_if out_if ();
  hdc_cfg_if cfg_if ();

  halfwave_dc_removal_and_qualifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and register copy
  logic [SampleBits-1:0] win_store [WindowDepth];
  logic [SumBits-1:0]    win_sum = '0;
  logic [SlotBits-1:0]   write_slot = '0;
  int                    fill_count = 0;
  logic [LossBits-1:0]   since_present = '1;
  logic [ClipBits-1:0]   clip_run = '0;
  logic [SampleBits-1:0] reg_present = 12'd200;
  logic [LossBits-1:0]   reg_loss = 16'd1000;
  logic [SampleBits-1:0] reg_clip = 12'd4000;
  logic [ClipBits-1:0]   reg_confirm = 8'd3;
  logic [GainBits-1:0]   reg_gain = 16'd8192;

  grid_result_t pending_results[$];
  int           mismatches = 0;
  int           cycles = 0;
  pace_e        pace = PACE_FREE;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;

  int burst_kind = 0;
  int burst_left = 0;
  int burst_amp = 0;
  int burst_period = 8;
  int burst_phase = 0;

  // Directed samples at reset settings; only the first two are typed in
  probe_row_t probes [20] = '{
    '{12'd4095, 1'b1, '{16'd65520, 16'sd0, 1'b0, 1'b0}},
    '{12'd0,    1'b1, '{16'd32760, -16'sd8190, 1'b0, 1'b0}},
    '{12'd4095, 1'b0, '0},
    '{12'd4095, 1'b0, '0},
    '{12'd4095, 1'b0, '0},
    '{12'd4095, 1'b0, '0},
    '{12'd3999, 1'b0, '0},
    '{12'd4000, 1'b0, '0},
    '{12'd4000, 1'b0, '0},
    '{12'd4000, 1'b0, '0},
    '{12'd199,  1'b0, '0},
    '{12'd200,  1'b0, '0},
    '{12'd1,    1'b0, '0},
    '{12'h800,  1'b0, '0},
    '{12'hAAA,  1'b0, '0},
    '{12'h555,  1'b0, '0},
    '{12'h7FF,  1'b0, '0},
    '{12'hFFE,  1'b0, '0},
    '{12'd0,    1'b0, '0},
    '{12'd1,    1'b0, '0}
  };

  reg_phase_t phases [5] = '{
    '{16'd0,    16'd1,     16'd4095,  16'd1,     16'd65535, PACE_SENDER,   150},
    '{16'd4095, 16'd65535, 16'd0,     16'd255,   16'd0,     PACE_RECEIVER, 280},
    '{16'd300,  16'd0,     16'd3500,  16'd0,     16'd40000, PACE_BOTH,     100},
    '{16'd300,  16'd20,    16'd3500,  16'd4,     16'd20000, PACE_FREE,     150},
    '{16'hF0C8, 16'd65534, 16'hFF00,  16'h0102,  16'h1234,  PACE_SENDER,   150}
  };

  function automatic grid_result_t qualify_sample(logic [SampleBits-1:0] s);
    longint       mean, diff, prod, ctr;
    grid_result_t r;
    if (fill_count < WindowDepth) begin
      win_sum += SumBits'(s);
      fill_count++;
    end else begin
      win_sum = win_sum - SumBits'(win_store[write_slot]) + SumBits'(s);
    end
    win_store[write_slot] = s;
    write_slot = (write_slot == SlotBits'(WindowDepth - 1)) ? '0 : write_slot + 1'b1;
    mean = (longint'(win_sum) * 16) / fill_count;
    diff = longint'(s) * 16 - mean;
    prod = diff * longint'(reg_gain);
    ctr = prod >>> GainShift;
    if (ctr > 32767) ctr = 32767;
    if (ctr < -32768) ctr = -32768;
    if (s >= reg_present) since_present = '0;
    else if (since_present < reg_loss) since_present++;
    if (s >= reg_clip) begin
      if (clip_run < reg_confirm) clip_run++;
    end else begin
      clip_run = '0;
    end
    r.mean_q4 = mean[MeanBits-1:0];
    r.ac_scaled = ctr[CenterBits-1:0];
    r.clipped = (clip_run >= reg_confirm);
    r.signal_valid = (fill_count >= WindowDepth) && (since_present < reg_loss) && !r.clipped;
    return r;
  endfunction

  // Bursts of half-wave shapes, noise, clipping runs and low stretches
  function automatic logic [SampleBits-1:0] next_grid_sample();
    int t, half, v;
    if (burst_left == 0) begin
      burst_kind = $urandom_range(0, 19);
      burst_left = $urandom_range(8, 80);
      burst_amp = $urandom_range(0, SampleMax);
      burst_period = $urandom_range(8, 40);
      burst_phase = 0;
    end
    burst_left--;
    burst_phase++;
    if (burst_kind < 10) begin
      half = burst_period / 2;
      t = burst_phase % burst_period;
      if (t < half) v = burst_amp * 2 * ((t < half / 2) ? t : half - t) / half
                        + $urandom_range(0, 15);
      else v = $urandom_range(0, 40);
    end else if (burst_kind < 14) begin
      v = $urandom_range(0, SampleMax);
    end else if (burst_kind < 17) begin
      v = SampleMax - $urandom_range(0, 150);
    end else begin
      v = $urandom_range(0, 150);
    end
    if (v > SampleMax) v = SampleMax;
    return v[SampleBits-1:0];
  endfunction

  function automatic int sender_idle_pct();
    return (pace == PACE_SENDER) ? 55 : (pace == PACE_BOTH) ? 6 : 0;
  endfunction

  function automatic int receiver_stall_pct();
    return (pace == PACE_RECEIVER) ? 55 : (pace == PACE_BOTH) ? 6 : 0;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= PrintLimit) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_sample(logic [SampleBits-1:0] s, bit typed, grid_result_t typed_res);
    grid_result_t r;
    int           pct;
    pct = sender_idle_pct();
    if (pct > 0 && $urandom_range(99) < pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    in_if.valid <= 1'b1;
    in_if.grid_sample <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = qualify_sample(s);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_PRESENT_LEVEL: reg_present = val[SampleBits-1:0];
      CFG_LOSS_LIMIT:    reg_loss = val[LossBits-1:0];
      CFG_CLIP_LEVEL:    reg_clip = val[SampleBits-1:0];
      CFG_CLIP_CONFIRM:  reg_confirm = val[ClipBits-1:0];
      CFG_PU_GAIN:       reg_gain = val[GainBits-1:0];
      default: ;
    endcase
  endtask

  task automatic load_phase(reg_phase_t ph);
    while (pending_results.size() != 0) @(posedge clk_i);
    write_reg(CFG_PRESENT_LEVEL, ph.present);
    write_reg(CFG_LOSS_LIMIT, ph.loss);
    write_reg(CFG_CLIP_LEVEL, ph.clip);
    write_reg(CFG_CLIP_CONFIRM, ph.confirm);
    write_reg(CFG_PU_GAIN, ph.gain);
    cfg_if.valid <= 1'b0;
    pace = ph.pace;
  endtask

  task automatic run_random(int n, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_requests++;
      send_sample(next_grid_sample(), 1'b0, '0);
    end
    in_if.valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HoldCycles;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= receiver_stall_pct());
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    grid_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no sample outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_if.mean_q4 !== want.mean_q4)
          flag_mismatch($sformatf("mean_q4 %0d, want %0d", out_if.mean_q4, want.mean_q4));
        if (out_if.ac_scaled !== want.ac_scaled)
          flag_mismatch($sformatf("ac_scaled %0d, want %0d",
                                  out_if.ac_scaled, want.ac_scaled));
        if (out_if.signal_valid !== want.signal_valid)
          flag_mismatch($sformatf("signal_valid %0b, want %0b",
                                  out_if.signal_valid, want.signal_valid));
        if (out_if.clipped !== want.clipped)
          flag_mismatch($sformatf("clipped %0b, want %0b", out_if.clipped, want.clipped));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reg_phase_t ph;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.grid_sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) send_sample(probes[i].sample, probes[i].typed, probes[i].want);
    // Fill the window at reset settings, with one long receiver hold-off
    run_random(330, 150);

    foreach (phases[i]) begin
      load_phase(phases[i]);
      // Unused indices must leave every register alone
      if (i == 0) begin
        @(posedge clk_i);
        for (int k = int'(CFG_PU_GAIN) + 1; k < (1 << CfgIdxBits); k++)
          write_reg(CfgIdxBits'(k), CfgDataBits'($urandom));
        cfg_if.valid <= 1'b0;
      end
      run_random(phases[i].items, -1);
    end

    repeat (2) begin
      ph.present = CfgDataBits'($urandom_range(0, SampleMax));
      ph.loss = CfgDataBits'($urandom_range(1, 64));
      ph.clip = CfgDataBits'($urandom_range(SampleMax / 2, SampleMax));
      ph.confirm = CfgDataBits'($urandom_range(1, 8));
      ph.gain = CfgDataBits'($urandom);
      ph.pace = pace_e'($urandom_range(0, 3));
      load_phase(ph);
      run_random(90, -1);
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
